/* hdl/assert_macros.svh */
// Assertion macros used by the RTL top level.
// Define NO_ASSERTIONS to compile them away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

/* hdl/mjpid_pkg.sv */
// Package for the multi-joint PID block: commands, status codes, item types.
// No dependencies.
package mjpid_pkg;
    localparam int POS_W = 32;
    localparam int MAX_J = 7;

    typedef enum logic [1:0] {
        CMD_UPDATE = 2'd0,
        CMD_GOAL   = 2'd1,
        CMD_LIMIT  = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_COMMAND  = 3'd0,
        ST_GOAL     = 3'd1,
        ST_GOAL_CLR = 3'd2,
        ST_REJECT   = 3'd3,
        ST_LIMITS   = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        REG_KP    = 3'd0,
        REG_KI    = 3'd1,
        REG_KD    = 3'd2,
        REG_MAX   = 3'd3,
        REG_DB    = 3'd4,
        REG_JUMP  = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [1:0]              cmd;
        logic signed [31:0]      pos_0;
        logic signed [31:0]      pos_1;
        logic signed [31:0]      pos_2;
        logic signed [31:0]      pos_3;
        logic signed [31:0]      pos_4;
        logic signed [31:0]      pos_5;
        logic signed [31:0]      pos_6;
        logic [2:0]              limit_joint;
        logic signed [31:0]      limit_min;
        logic signed [31:0]      limit_max;
    } in_item_t;

    typedef struct packed {
        logic [2:0]         joint_out;
        logic signed [31:0] position_command;
        logic [2:0]         status;
        logic               last;
    } out_item_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction
endpackage

/* hdl/mjpid_if.sv */
// Valid/ready channel interfaces for input and result items.
// Depends on mjpid_pkg.
interface mjpid_in_if;
    logic                valid;
    logic                ready;
    mjpid_pkg::in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface mjpid_out_if;
    logic                 valid;
    logic                 ready;
    mjpid_pkg::out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* hdl/multi_joint_pid_position_control.sv */
// Seven-joint position PID top level.
// Depends on mjpid_pkg, mjpid_if, mjpid_term, assert_macros.svh.
//
// Channels: in_ch (sink) takes items with cmd: 0 control update with all
// measured positions, 1 new goal set, 2 load one joint's limits. out_ch
// (source) returns results; the final result of an item has last set.
// Config: cfg_we/cfg_index/cfg_data writes kp, ki_dt, kd_div_dt, max_step,
// deadband, jump_threshold (index 0..5). The user must write them only
// while idle; the block itself does not enforce it. Per-joint state (goal,
// integral, previous error, limits) lives in one memory word per joint with
// a synchronous, registered read. Update: per joint the steps read, error,
// multiply, sum, write back and emit run in order, then the next joint's
// read. No new item is taken until the last joint's result is emitted.
// Goal: a read and check pass over all joints, then a write pass storing
// each joint's goal (skipped if rejected), then emit. Limit: the target
// joint's word is read, then written if the joint is in range, and emitted.
// Reset: a clearing pass writes reset values into every joint's memory
// word; no item is taken meanwhile. A stalled receiver holds the result
// register; the sequencer waits in its emit step. cmd 3 items are dropped.
`include "assert_macros.svh"
module multi_joint_pid_position_control #(
    parameter int NUM_JOINTS    = 7,
    parameter int INTEGRAL_BITS = 48
) (
    input  logic              clk,
    input  logic              rst_n,
    mjpid_in_if.sink          in_ch,
    mjpid_out_if.source       out_ch,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [31:0]       cfg_data
);
    localparam int JW = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
    localparam int IB = INTEGRAL_BITS;

    typedef struct packed {
        logic signed [31:0]    goal;
        logic signed [IB-1:0]  integ;
        logic signed [31:0]    perr;
        logic signed [31:0]    lmin;
        logic signed [31:0]    lmax;
    } jstate_t;

    typedef enum logic [10:0] {
        S_INIT   = 11'b00000000001,
        S_IDLE   = 11'b00000000010,
        S_URD    = 11'b00000000100,
        S_UCALC  = 11'b00000001000,
        S_UMUL   = 11'b00000010000,
        S_USUM   = 11'b00000100000,
        S_UOUT   = 11'b00001000000,
        S_GCHK   = 11'b00010000000,
        S_GWR    = 11'b00100000000,
        S_ONE    = 11'b01000000000,
        S_GRD    = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    jstate_t mem [NUM_JOINTS];
    jstate_t rd_reg;
    logic    mem_we;
    logic [JW-1:0] mem_wa, mem_ra;
    jstate_t mem_wd;

    logic signed [31:0] kp_reg, ki_reg, kd_reg;
    logic [30:0] max_reg, db_reg, jump_reg;

    mjpid_pkg::in_item_t item_reg;
    logic [JW-1:0] j_reg, j_next;
    logic signed [31:0] pos_cur;
    logic signed [31:0] err_reg;
    logic signed [IB-1:0] int_reg;
    logic signed [63:0] a_p, a_i, a_d, q_p, q_i, q_d;
    logic signed [31:0] g_p;
    logic signed [63:0] dsum_reg;
    logic rej_reg;
    logic ov_reg;
    mjpid_pkg::out_item_t ov_data_reg;
    logic out_free;
    logic emit;
    logic clr_hit;
    logic lim_ok_in, lim_ok;
    logic [1:0] mul_cnt_reg;
    logic signed [IB:0] isum;
    logic signed [IB-1:0] imax, imin, inew;
    logic signed [65:0] tsum;
    logic signed [65:0] max_w, db_w;
    logic signed [63:0] step;
    logic signed [33:0] gdiff;

    // Per-joint position select
    always_comb
    begin
        case (j_reg)
            JW'(0): pos_cur = item_reg.pos_0;
            JW'(1): pos_cur = item_reg.pos_1;
            JW'(2): pos_cur = item_reg.pos_2;
            JW'(3): pos_cur = item_reg.pos_3;
            JW'(4): pos_cur = item_reg.pos_4;
            JW'(5): pos_cur = item_reg.pos_5;
            default: pos_cur = item_reg.pos_6;
        endcase
    end

    // Joint memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        rd_reg <= mem[mem_ra];
    end

    // Configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg <= '0; ki_reg <= '0; kd_reg <= '0;
            max_reg <= '0; db_reg <= '0; jump_reg <= 31'd16777216;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mjpid_pkg::REG_KP:   kp_reg   <= cfg_data;
                mjpid_pkg::REG_KI:   ki_reg   <= cfg_data;
                mjpid_pkg::REG_KD:   kd_reg   <= cfg_data;
                mjpid_pkg::REG_MAX:  max_reg  <= cfg_data[30:0];
                mjpid_pkg::REG_DB:   db_reg   <= cfg_data[30:0];
                mjpid_pkg::REG_JUMP: jump_reg <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // Shared term multipliers; their partial products of a are registered
    assign a_p = 64'(err_reg);
    assign a_i = 64'(int_reg);
    assign a_d = 64'(err_reg) - 64'(rd_reg.perr);
    assign g_p = kp_reg;
    mjpid_term u_tp (.clk(clk), .a(a_p), .g(g_p),    .q(q_p));
    mjpid_term u_ti (.clk(clk), .a(a_i), .g(ki_reg), .q(q_i));
    mjpid_term u_td (.clk(clk), .a(a_d), .g(kd_reg), .q(q_d));

    // Integral, saturating
    always_comb
    begin
        imax = {1'b0, {(IB-1){1'b1}}};
        imin = {1'b1, {(IB-1){1'b0}}};
        isum = (IB+1)'(rd_reg.integ) + (IB+1)'(err_reg);
        if (isum > (IB+1)'(imax)) inew = imax;
        else if (isum < (IB+1)'(imin)) inew = imin;
        else inew = isum[IB-1:0];
    end

    // Sum, clamp, deadband
    always_comb
    begin
        max_w = $signed(66'(max_reg));
        db_w  = $signed(66'(db_reg));
        tsum = 66'(q_p) + 66'(q_i) + 66'(q_d);
        if (tsum > max_w) step = max_w[63:0];
        else if (tsum < -max_w) step = 64'(-max_w);
        else if (((tsum < 0) ? -tsum : tsum) < db_w) step = '0;
        else step = tsum[63:0];
    end

    assign gdiff = 34'(pos_cur) - 34'(rd_reg.goal);
    assign clr_hit = dsum_reg > $signed(64'(jump_reg));
    assign lim_ok_in = {1'b0, in_ch.data.limit_joint} < 4'(NUM_JOINTS);
    assign lim_ok = {1'b0, item_reg.limit_joint} < 4'(NUM_JOINTS);
    assign out_free = !ov_reg || out_ch.ready;
    assign emit = (state_reg == S_UOUT || state_reg == S_ONE) && out_free;
    assign in_ch.ready = (state_reg == S_IDLE) && out_free;
    assign out_ch.valid = ov_reg;
    assign out_ch.data = ov_data_reg;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        j_next = j_reg;
        mem_we = 1'b0;
        mem_wa = j_reg;
        mem_ra = j_reg;
        mem_wd = rd_reg;
        case (state_reg)
            S_INIT:
            begin
                mem_we = 1'b1;
                mem_wd.goal = '0;
                mem_wd.integ = '0;
                mem_wd.perr = '0;
                mem_wd.lmin = 32'sh80000000;
                mem_wd.lmax = 32'sh7fffffff;
                if (j_reg == JW'(NUM_JOINTS - 1))
                begin
                    state_next = S_IDLE;
                    j_next = '0;
                end
                else
                    j_next = j_reg + JW'(1);
            end
            S_IDLE:
            begin
                mem_ra = '0;
                if (in_ch.valid && in_ch.ready)
                begin
                    j_next = '0;
                    case (in_ch.data.cmd)
                        mjpid_pkg::CMD_UPDATE: state_next = S_URD;
                        mjpid_pkg::CMD_GOAL:   state_next = S_GRD;
                        mjpid_pkg::CMD_LIMIT:
                        begin
                            // fetch the target joint's word for the limit write
                            state_next = S_ONE;
                            if (lim_ok_in)
                            begin
                                j_next = JW'(in_ch.data.limit_joint);
                                mem_ra = JW'(in_ch.data.limit_joint);
                            end
                        end
                        default:               state_next = S_IDLE;
                    endcase
                end
            end
            S_URD:  state_next = S_UCALC;
            S_UCALC: state_next = S_UMUL;
            S_UMUL: if (mul_cnt_reg == 2'd1) state_next = S_USUM;
            S_USUM: state_next = S_UOUT;
            S_UOUT:
            begin
                if (out_free)
                begin
                    mem_we = 1'b1;
                    mem_wd.integ = int_reg;
                    mem_wd.perr = err_reg;
                    if (j_reg == JW'(NUM_JOINTS - 1))
                        state_next = S_IDLE;
                    else
                    begin
                        j_next = j_reg + JW'(1);
                        mem_ra = j_reg + JW'(1);
                        state_next = S_URD;
                    end
                end
            end
            S_GRD: state_next = S_GCHK;
            S_GCHK:
            begin
                if (j_reg == JW'(NUM_JOINTS - 1))
                begin
                    j_next = '0;
                    mem_ra = '0;
                    state_next = S_GWR;
                end
                else
                begin
                    j_next = j_reg + JW'(1);
                    mem_ra = j_reg + JW'(1);
                    state_next = S_GRD;
                end
            end
            S_GWR:
            begin
                // one joint per cycle: store goal, clear history on a jump; no write if rejected
                if (rej_reg)
                    state_next = S_ONE;
                else
                begin
                    mem_we = 1'b1;
                    mem_wd.goal = pos_cur;
                    if (clr_hit)
                    begin
                        mem_wd.integ = '0;
                        mem_wd.perr = '0;
                    end
                    if (j_reg == JW'(NUM_JOINTS - 1))
                        state_next = S_ONE;
                    else
                    begin
                        j_next = j_reg + JW'(1);
                        mem_ra = j_reg + JW'(1);
                    end
                end
            end
            S_ONE:
            begin
                if (out_free)
                begin
                    if (item_reg.cmd == mjpid_pkg::CMD_LIMIT && lim_ok)
                    begin
                        mem_we = 1'b1;
                        mem_wd.lmin = item_reg.limit_min;
                        mem_wd.lmax = item_reg.limit_max;
                    end
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Item path registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            j_reg <= '0;
            ov_reg <= 1'b0;
            ov_data_reg <= '0;
            mul_cnt_reg <= '0;
            rej_reg <= 1'b0;
            dsum_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            j_reg <= j_next;
            if (emit)
                ov_reg <= 1'b1;
            else if (out_ch.ready)
                ov_reg <= 1'b0;
            if (state_reg == S_UMUL)
                mul_cnt_reg <= mul_cnt_reg + 2'd1;
            else
                mul_cnt_reg <= '0;
            if (state_reg == S_IDLE)
            begin
                rej_reg <= 1'b0;
                dsum_reg <= '0;
            end
            if (state_reg == S_GCHK)
            begin
                if (pos_cur < rd_reg.lmin || pos_cur > rd_reg.lmax)
                    rej_reg <= 1'b1;
                dsum_reg <= dsum_reg + ((gdiff < 0) ? 64'(-gdiff) : 64'(gdiff));
            end
            if (state_reg == S_UOUT && out_free)
            begin
                ov_data_reg.joint_out <= 3'(j_reg);
                ov_data_reg.position_command <=
                    mjpid_pkg::sat32(64'(pos_cur) + step);
                ov_data_reg.status <= mjpid_pkg::ST_COMMAND;
                ov_data_reg.last <= (j_reg == JW'(NUM_JOINTS - 1));
            end
            if (state_reg == S_ONE && out_free)
            begin
                ov_data_reg.position_command <= '0;
                ov_data_reg.last <= 1'b1;
                if (item_reg.cmd == mjpid_pkg::CMD_LIMIT)
                begin
                    ov_data_reg.joint_out <= item_reg.limit_joint;
                    ov_data_reg.status <= mjpid_pkg::ST_LIMITS;
                end
                else
                begin
                    ov_data_reg.joint_out <= '0;
                    if (rej_reg)
                        ov_data_reg.status <= mjpid_pkg::ST_REJECT;
                    else if (clr_hit)
                        ov_data_reg.status <= mjpid_pkg::ST_GOAL_CLR;
                    else
                        ov_data_reg.status <= mjpid_pkg::ST_GOAL;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_ch.valid && in_ch.ready)
            item_reg <= in_ch.data;
        if (state_reg == S_UCALC)
            err_reg <= mjpid_pkg::sat32(64'(rd_reg.goal) - 64'(pos_cur));
        if (state_reg == S_UMUL && mul_cnt_reg == 2'd0)
            int_reg <= inew;
    end

    `ASSERT_NEVER(a_out_in_init, clk, rst_n, ov_reg && state_reg == S_INIT)
    `ASSERT_IMPL(a_hold, clk, rst_n, (ov_reg && !out_ch.ready) |=> ov_reg)
    `ASSERT_IMPL(a_ready_idle, clk, rst_n, in_ch.ready |-> state_reg == S_IDLE)
endmodule

/* hdl/mjpid_term.sv */
// Gain term: floor(a * g / 2^16) saturated to +-2^62, one register stage.
// Operand up to 64 bits split in 33x32 and 32x32 partial products.
module mjpid_term (
    input  logic               clk,
    input  logic signed [63:0] a,
    input  logic signed [31:0] g,
    output logic signed [63:0] q
);
    logic signed [64:0] p_lo_reg;
    logic signed [64:0] p_hi_reg;
    logic signed [97:0] full;
    logic signed [81:0] sh;

    always_ff @(posedge clk)
    begin
        p_lo_reg <= $signed({1'b0, a[31:0]}) * g;
        p_hi_reg <= $signed(a[63:32]) * g;
    end

    always_comb
    begin
        full = (98'(p_hi_reg) <<< 32) + 98'(p_lo_reg);
        sh   = 82'(full >>> 16);
        if (sh > 82'sd4611686018427387904)
            q = 64'sh4000000000000000;
        else if (sh < -82'sd4611686018427387904)
            q = -64'sh4000000000000000;
        else
            q = sh[63:0];
    end
endmodule

/* test/multi_joint_pid_position_control_tb.sv */
// Self-checking testbench for the seven-joint position PID block.
// Depends on mjpid_pkg, mjpid_if and the multi_joint_pid_position_control RTL.
module multi_joint_pid_position_control_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int JOINTS = 7;
    localparam logic signed [63:0] TERM_CAP = 64'sd1 <<< 62;
    localparam logic signed [63:0] INTEG_HI = (64'sd1 <<< 47) - 1;
    localparam logic signed [63:0] INTEG_LO = -(64'sd1 <<< 47);
    localparam logic signed [63:0] P32_HI = 64'sd2147483647;
    localparam logic signed [63:0] P32_LO = -64'sd2147483648;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    mjpid_in_if  in_ch();
    mjpid_out_if out_ch();

    multi_joint_pid_position_control dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Predictor copy of gains and limits (register values as written)
    logic signed [31:0] gain_p, gain_i, gain_d;
    logic signed [63:0] step_cap, dead_zone, jump_limit;
    // Predictor copy of per-joint state
    logic signed [63:0] goal_q [JOINTS];
    logic signed [63:0] integ_q [JOINTS];
    logic signed [63:0] prev_err_q [JOINTS];
    logic signed [63:0] lim_lo [JOINTS];
    logic signed [63:0] lim_hi [JOINTS];

    mjpid_pkg::in_item_t  stim_q[$];       // items waiting for the driver
    mjpid_pkg::out_item_t pending_cmds[$]; // results the block still owes us
    int        fail_count = 0;
    bit        quiet = 1'b0;    // no idling on either side
    int        hold_ask = 0;    // bump to request one long receiver hold-off

    function automatic logic signed [63:0] clip(logic signed [63:0] v,
                                                logic signed [63:0] lo,
                                                logic signed [63:0] hi);
        return (v > hi) ? hi : ((v < lo) ? lo : v);
    endfunction

    // floor(a * g / 2^16), clamped to +-2^62
    function automatic logic signed [63:0] gain_term(logic signed [63:0] a,
                                                     logic signed [31:0] g);
        logic signed [95:0] prod;
        prod = $signed({{32{a[63]}}, a}) * $signed({{64{g[31]}}, g});
        prod = prod >>> 16;
        if (prod > $signed({{32{1'b0}}, TERM_CAP})) return TERM_CAP;
        if (prod < -$signed({{32{1'b0}}, TERM_CAP})) return -TERM_CAP;
        return prod[63:0];
    endfunction

    function automatic mjpid_pkg::out_item_t mk_res(logic [2:0] j,
                                                    logic signed [31:0] pc,
                                                    mjpid_pkg::status_t st,
                                                    logic lst);
        mjpid_pkg::out_item_t r;
        r.joint_out = j;
        r.position_command = pc;
        r.status = st;
        r.last = lst;
        return r;
    endfunction

    // Advance the predictor by one accepted item and queue what it owes
    task automatic predict_item(mjpid_pkg::in_item_t it);
        logic signed [63:0] pos [JOINTS];
        logic signed [63:0] err, goal_move, step;
        logic signed [65:0] total;
        bit rejected;
        mjpid_pkg::status_t st;
        pos = '{it.pos_0, it.pos_1, it.pos_2, it.pos_3, it.pos_4, it.pos_5, it.pos_6};
        case (mjpid_pkg::cmd_t'(it.cmd))
            mjpid_pkg::CMD_UPDATE: begin
                for (int j = 0; j < JOINTS; j++) begin
                    err = clip(goal_q[j] - pos[j], P32_LO, P32_HI);
                    integ_q[j] = clip(integ_q[j] + err, INTEG_LO, INTEG_HI);
                    total = 66'(gain_term(err, gain_p)) + 66'(gain_term(integ_q[j], gain_i))
                          + 66'(gain_term(err - prev_err_q[j], gain_d));
                    if (total > step_cap) step = step_cap;
                    else if (total < -step_cap) step = -step_cap;
                    else if ((total < 0 ? -total : total) < dead_zone) step = 0;
                    else step = total[63:0];
                    prev_err_q[j] = err;
                    pending_cmds.push_back(mk_res(3'(j),
                        32'(clip(pos[j] + step, P32_LO, P32_HI)), mjpid_pkg::ST_COMMAND,
                        j == JOINTS - 1));
                end
            end
            mjpid_pkg::CMD_GOAL: begin
                rejected = 1'b0;
                goal_move = 0;
                for (int j = 0; j < JOINTS; j++) begin
                    if (pos[j] < lim_lo[j] || pos[j] > lim_hi[j]) rejected = 1'b1;
                    goal_move += (pos[j] > goal_q[j]) ? pos[j] - goal_q[j]
                                                      : goal_q[j] - pos[j];
                end
                if (rejected) st = mjpid_pkg::ST_REJECT;
                else begin
                    st = mjpid_pkg::ST_GOAL;
                    if (goal_move > jump_limit) begin
                        st = mjpid_pkg::ST_GOAL_CLR;
                        for (int j = 0; j < JOINTS; j++) begin
                            integ_q[j] = 0;
                            prev_err_q[j] = 0;
                        end
                    end
                    for (int j = 0; j < JOINTS; j++) goal_q[j] = pos[j];
                end
                pending_cmds.push_back(mk_res(3'd0, 32'sd0, st, 1'b1));
            end
            mjpid_pkg::CMD_LIMIT: begin
                if (it.limit_joint < JOINTS) begin
                    lim_lo[it.limit_joint] = it.limit_min;
                    lim_hi[it.limit_joint] = it.limit_max;
                end
                pending_cmds.push_back(mk_res(it.limit_joint, 32'sd0,
                                              mjpid_pkg::ST_LIMITS, 1'b1));
            end
            default: ; // unused command: dropped, nothing owed
        endcase
    endtask

    // Driver: offers queued items, with random gaps unless quiet
    int gap_left = 0;
    always @(posedge clk) begin
        bit                  nv;
        mjpid_pkg::in_item_t nd;
        nv = in_ch.valid;
        nd = in_ch.data;
        if (!rst_n) begin
            nv = 1'b0;
            nd = '0;
        end else if (in_ch.valid && in_ch.ready) begin
            predict_item(in_ch.data);
            nv = 1'b0;
        end
        if (rst_n && !(in_ch.valid && !in_ch.ready)) begin
            if (gap_left > 0) gap_left--;
            else if (!quiet && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 19) - 1;
            else if (stim_q.size() > 0) begin
                nd = stim_q.pop_front();
                nv = 1'b1;
            end
        end
        in_ch.valid <= nv;
        in_ch.data <= nd;
    end

    // Monitor: random back-pressure, long hold-offs on request, checking
    int stall_left = 0;
    int hold_seen = 0;
    always @(posedge clk) begin
        mjpid_pkg::out_item_t want;
        bit                   nr;
        if (out_ch.valid && out_ch.ready) begin
            if (pending_cmds.size() == 0) begin
                $error("unexpected result joint %0d cmd %0d status %0d",
                       out_ch.data.joint_out, out_ch.data.position_command,
                       out_ch.data.status);
                fail_count++;
            end else begin
                want = pending_cmds.pop_front();
                if (out_ch.data.joint_out !== want.joint_out) begin
                    $error("joint_out expected %0d actual %0d",
                           want.joint_out, out_ch.data.joint_out);
                    fail_count++;
                end
                if (out_ch.data.position_command !== want.position_command) begin
                    $error("position_command expected %0d actual %0d",
                           want.position_command, out_ch.data.position_command);
                    fail_count++;
                end
                if (out_ch.data.status !== want.status) begin
                    $error("status expected %0d actual %0d", want.status, out_ch.data.status);
                    fail_count++;
                end
                if (out_ch.data.last !== want.last) begin
                    $error("last expected %0d actual %0d", want.last, out_ch.data.last);
                    fail_count++;
                end
            end
        end
        nr = 1'b1;
        if (hold_seen != hold_ask) begin
            hold_seen = hold_ask;
            stall_left = 400;   // long enough to back the block up to its input
        end
        if (stall_left > 0) begin
            stall_left--;
            nr = 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 19) - 1;
            nr = 1'b0;
        end
        out_ch.ready <= nr;
    end

    initial begin
        gain_p = 0; gain_i = 0; gain_d = 0;
        step_cap = 0; dead_zone = 0; jump_limit = 64'sd16777216;
        for (int j = 0; j < JOINTS; j++) begin
            goal_q[j] = 0; integ_q[j] = 0; prev_err_q[j] = 0;
            lim_lo[j] = P32_LO; lim_hi[j] = P32_HI;
        end
    end

    // Run limit, far above the slowest legal run
    initial begin
        #5ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic write_reg(mjpid_pkg::reg_idx_t idx, logic [31:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            mjpid_pkg::REG_KP:   gain_p = val;
            mjpid_pkg::REG_KI:   gain_i = val;
            mjpid_pkg::REG_KD:   gain_d = val;
            mjpid_pkg::REG_MAX:  step_cap = {33'd0, val[30:0]};
            mjpid_pkg::REG_DB:   dead_zone = {33'd0, val[30:0]};
            mjpid_pkg::REG_JUMP: jump_limit = {33'd0, val[30:0]};
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic write_all(logic [31:0] kp, logic [31:0] ki, logic [31:0] kd,
                             logic [31:0] mx, logic [31:0] db, logic [31:0] jt);
        write_reg(mjpid_pkg::REG_KP, kp);
        write_reg(mjpid_pkg::REG_KI, ki);
        write_reg(mjpid_pkg::REG_KD, kd);
        write_reg(mjpid_pkg::REG_MAX, mx);
        write_reg(mjpid_pkg::REG_DB, db);
        write_reg(mjpid_pkg::REG_JUMP, jt);
    endtask

    // Idle point: queue empty, nothing owed, plus slack for dropped items
    task automatic drain();
        while (stim_q.size() > 0 || in_ch.valid || pending_cmds.size() > 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    function automatic mjpid_pkg::in_item_t base_item(mjpid_pkg::cmd_t c);
        mjpid_pkg::in_item_t it;
        it = '0;
        it.cmd = c;
        it.limit_joint = $urandom_range(0, 7);
        it.limit_min = $urandom;
        it.limit_max = $urandom;
        return it;
    endfunction

    function automatic mjpid_pkg::in_item_t pos_item(mjpid_pkg::cmd_t c,
                                                     logic signed [31:0] p [JOINTS]);
        mjpid_pkg::in_item_t it;
        it = base_item(c);
        {it.pos_0, it.pos_1, it.pos_2, it.pos_3, it.pos_4, it.pos_5, it.pos_6} =
            {p[0], p[1], p[2], p[3], p[4], p[5], p[6]};
        return it;
    endfunction

    // Positions near the current goals, sometimes anywhere in range
    function automatic mjpid_pkg::in_item_t rand_positions(mjpid_pkg::cmd_t c, int spread);
        logic signed [31:0] p [JOINTS];
        for (int j = 0; j < JOINTS; j++)
            if ($urandom_range(0, 7) == 0) p[j] = $urandom;
            else p[j] = 32'(goal_q[j]) + $signed(32'($urandom_range(0, 2 * spread))) - spread;
        return pos_item(c, p);
    endfunction

    function automatic mjpid_pkg::in_item_t rand_item();
        mjpid_pkg::in_item_t it;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60) it = rand_positions(mjpid_pkg::CMD_UPDATE, 1 << 22);
        else if (pick < 80) it = rand_positions(mjpid_pkg::CMD_GOAL, 1 << 23);
        else if (pick < 93) begin
            it = base_item(mjpid_pkg::CMD_LIMIT);
            if ($urandom_range(0, 2) != 0) begin
                // mostly a sane window around zero
                it.limit_min = -$signed(32'($urandom_range(1 << 24, 1 << 30)));
                it.limit_max = $urandom_range(1 << 24, 1 << 30);
            end
        end else it = rand_positions(mjpid_pkg::CMD_NONE, 1 << 20);
        return it;
    endfunction

    task automatic open_limits();
        mjpid_pkg::in_item_t it;
        for (int j = 0; j < JOINTS; j++) begin
            it = base_item(mjpid_pkg::CMD_LIMIT);
            it.limit_joint = j;
            it.limit_min = 32'sh80000000;
            it.limit_max = 32'sh7fffffff;
            stim_q.push_back(it);
        end
    endtask

    initial begin
        logic signed [31:0] p [JOINTS];
        mjpid_pkg::in_item_t it;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Moderate gains first, wide step limit, no deadband
        write_all(32'h0001_0000, 32'h0000_0100, 32'h0000_4000, 32'h7fff_ffff, 0, 1 << 24);

        // Directed: zero update, extreme positions, goals, limits, dropped command
        p = '{default: 0};
        stim_q.push_back(pos_item(mjpid_pkg::CMD_UPDATE, p));
        p = '{default: 32'sh7fffffff};
        stim_q.push_back(pos_item(mjpid_pkg::CMD_UPDATE, p));
        p = '{default: 32'sh80000000};
        stim_q.push_back(pos_item(mjpid_pkg::CMD_UPDATE, p));
        p = '{32'sh01000000, -32'sh01000000, 32'sh00800000, 0, 32'sh00000001, -1, 32'sh00400000};
        stim_q.push_back(pos_item(mjpid_pkg::CMD_GOAL, p));   // large move: history cleared
        p[0] = p[0] + 1;
        stim_q.push_back(pos_item(mjpid_pkg::CMD_GOAL, p));   // tiny move: plain take
        stim_q.push_back(pos_item(mjpid_pkg::CMD_UPDATE, p));
        it = base_item(mjpid_pkg::CMD_LIMIT);
        it.limit_joint = 3; it.limit_min = -32'sh02000000; it.limit_max = 32'sh02000000;
        stim_q.push_back(it);
        p[3] = 32'sh03000000;
        stim_q.push_back(pos_item(mjpid_pkg::CMD_GOAL, p));   // above joint 3 maximum
        p[3] = -32'sh03000000;
        stim_q.push_back(pos_item(mjpid_pkg::CMD_GOAL, p));   // below minimum
        it = base_item(mjpid_pkg::CMD_LIMIT);
        it.limit_joint = 7; it.limit_min = 0; it.limit_max = 0;
        stim_q.push_back(it);                                 // joint out of range
        it = base_item(mjpid_pkg::CMD_LIMIT);
        it.limit_joint = 5; it.limit_min = 32'sh00100000; it.limit_max = -32'sh00100000;
        stim_q.push_back(it);                                 // min above max
        p = '{default: 0};
        stim_q.push_back(pos_item(mjpid_pkg::CMD_GOAL, p));   // rejected by inverted window
        stim_q.push_back(pos_item(mjpid_pkg::CMD_NONE, p));   // dropped
        open_limits();
        p = '{default: 32'sh00200000};
        stim_q.push_back(pos_item(mjpid_pkg::CMD_UPDATE, p));
        drain();

        // Extremes of every register; receiver holds off while items keep coming
        write_all(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 0, 32'h7fff_ffff, 0);
        hold_ask++;
        for (int k = 0; k < 30; k++) stim_q.push_back(rand_item());
        open_limits();
        drain();

        write_all(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0, 32'h7fff_ffff);
        for (int k = 0; k < 30; k++) stim_q.push_back(rand_item());
        open_limits();
        drain();

        // Random realistic gains, step limit and deadband
        write_all($urandom_range(0, 1 << 18), $urandom_range(0, 1 << 10),
                  $urandom_range(0, 1 << 16), $urandom_range(1 << 18, 1 << 23),
                  $urandom_range(0, 1 << 16), $urandom_range(1 << 22, 1 << 26));
        for (int k = 0; k < 30; k++) stim_q.push_back(rand_item());
        open_limits();
        drain();

        // Tail: no idling on either side
        write_all(-$signed(32'($urandom_range(0, 1 << 18))), $urandom_range(0, 1 << 12),
                  $urandom, $urandom_range(1 << 20, 1 << 24),
                  $urandom_range(0, 1 << 18), $urandom_range(0, 1 << 25));
        quiet = 1'b1;
        for (int k = 0; k < 30; k++) stim_q.push_back(rand_item());
        drain();

        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

/* sim.f */
+incdir+hdl
hdl/mjpid_pkg.sv
hdl/mjpid_if.sv
hdl/mjpid_term.sv
hdl/multi_joint_pid_position_control.sv
test/multi_joint_pid_position_control_tb.sv
